// ===== sv/tmve_pkg.sv =====
package tmve_pkg;

    // input item action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_MOVE   = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;
    localparam logic [1:0] ACT_TARGET = 2'd3;

    // result command codes
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_VOL  = 2'd1;
    localparam logic [1:0] CMD_MUTE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_DWELL      = 3'd0;
    localparam logic [2:0] CFG_DWELL_FM   = 3'd1;
    localparam logic [2:0] CFG_PRECHARGE  = 3'd2;
    localparam logic [2:0] CFG_BLOOM      = 3'd3;
    localparam logic [2:0] CFG_MIN_VOLUME = 3'd4;
    localparam logic [2:0] CFG_MAX_VOLUME = 3'd5;
    localparam logic [2:0] CFG_SOFT_DROP  = 3'd6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VOL_W      = 6;
    localparam int MAX_RESULTS = 3;

    // configuration reset values
    localparam logic [15:0] RST_DWELL      = 16'd100;
    localparam logic [15:0] RST_DWELL_FM   = 16'd200;
    localparam logic [9:0]  RST_PRECHARGE  = 10'd10;
    localparam logic [9:0]  RST_BLOOM      = 10'd150;
    localparam logic [5:0]  RST_MIN_VOLUME = 6'd2;
    localparam logic [5:0]  RST_MAX_VOLUME = 6'd63;
    localparam logic        RST_SOFT_DROP  = 1'b1;
    localparam logic [5:0]  RST_LEVEL      = 6'd63;

    // defaults for top level parameters
    localparam int DEF_RAMP_TABLE_DEPTH = 150;
    localparam int DEF_TIME_BITS        = 32;
    localparam int DEF_QUEUE_DEPTH      = 4;

    localparam int RAMP_ROM_ENTRIES = 150;

    // sigmoid bloom curve
    localparam logic [5:0] RAMP_ROM [RAMP_ROM_ENTRIES] = '{
        6'd1,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd2,  6'd2,  6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd4,
        6'd4,  6'd4,  6'd4,  6'd4,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd6,
        6'd6,  6'd6,  6'd7,  6'd7,  6'd7,  6'd8,  6'd8,  6'd8,  6'd9,  6'd9,
        6'd9,  6'd10, 6'd10, 6'd11, 6'd11, 6'd11, 6'd12, 6'd12, 6'd13, 6'd13,
        6'd14, 6'd15, 6'd15, 6'd16, 6'd16, 6'd17, 6'd18, 6'd18, 6'd19, 6'd20,
        6'd20, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24, 6'd25, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd34, 6'd35,
        6'd35, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39, 6'd40, 6'd41, 6'd41, 6'd42,
        6'd43, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd48,
        6'd49, 6'd50, 6'd50, 6'd51, 6'd51, 6'd52, 6'd52, 6'd52, 6'd53, 6'd53,
        6'd54, 6'd54, 6'd54, 6'd55, 6'd55, 6'd55, 6'd56, 6'd56, 6'd56, 6'd57,
        6'd57, 6'd57, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd59, 6'd59, 6'd59,
        6'd59, 6'd59, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd60, 6'd61,
        6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd61, 6'd62, 6'd63
    };

    // one classified item: up to three commands plus the status after it
    typedef struct packed {
        logic [1:0]                               last_k;
        logic [MAX_RESULTS-1:0][1:0]              kind;
        logic [MAX_RESULTS-1:0][VOL_W-1:0]        value;
        logic [VOL_W-1:0]                         present;
        logic                                     busy;
        logic                                     owns;
    } job_t;

endpackage

// ===== sv/tmve_queue.sv =====
module tmve_queue #(
    parameter int DEPTH = tmve_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tmve_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output tmve_pkg::job_t head_job,
    output logic          empty
);
    import tmve_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/tmve_front.sv =====
module tmve_front #(
    parameter int RAMP_TABLE_DEPTH = tmve_pkg::DEF_RAMP_TABLE_DEPTH,
    parameter int TIME_BITS        = tmve_pkg::DEF_TIME_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tmve_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tmve_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [15:0]                       in_data,
    input  logic                              q_full,
    output logic                              q_push,
    output tmve_pkg::job_t                    q_job
);
    import tmve_pkg::*;

    localparam int ROM_LEN  = (RAMP_TABLE_DEPTH < RAMP_ROM_ENTRIES) ?
                              RAMP_TABLE_DEPTH : RAMP_ROM_ENTRIES;
    localparam int LAST_IDX = ROM_LEN - 1;
    localparam int IDX_W    = $clog2(ROM_LEN);

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DROP  = 2'd1;
    localparam logic [1:0] PH_DWELL = 2'd2;
    localparam logic [1:0] PH_BLOOM = 2'd3;

    // configuration
    logic [15:0] dwell_reg;
    logic [15:0] dwell_fm_reg;
    logic [9:0]  precharge_reg;
    logic [9:0]  bloom_reg;
    logic [5:0]  min_vol_reg;
    logic [5:0]  max_vol_reg;
    logic        soft_drop_reg;

    // sequencer and held item
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic [1:0]  it_action_reg;
    logic        it_active_reg;
    logic        it_muted_reg;
    logic        it_fm_reg;
    logic [7:0]  it_volume_reg;

    // envelope state
    logic [1:0]           phase_reg, phase_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] move_reg, move_next;
    logic [TIME_BITS-1:0] ramp_reg, ramp_next;
    logic [5:0]           target_reg, target_next;
    logic [5:0]           held_reg, held_next;
    logic                 unmuted_reg, unmuted_next;
    logic                 active_reg, active_next;
    logic                 muted_reg, muted_next;
    logic                 fm_reg, fm_next;

    // timing decisions from the eval step
    logic             ev_dwell_done_reg;
    logic             ev_ramp_end_reg;
    logic             ev_ramp_pre_reg;
    logic [IDX_W-1:0] ev_idx_reg;

    logic                 take;
    logic                 apply_go;
    logic [TIME_BITS-1:0] el_dwell;
    logic [TIME_BITS-1:0] el_ramp;
    logic [TIME_BITS-1:0] el_curve;
    logic [10:0]          ramp_total;
    logic [15:0]          dwell_sel;
    logic [5:0]           lut;
    logic [5:0]           lut_floor;
    logic [5:0]           goal;
    logic [11:0]          prod;
    logic [5:0]           quot;
    logic [6:0]           rem_sum;
    logic [5:0]           bloom_vol;
    job_t                 job;

    assign apply_go = (step_reg == ST_APPLY) && !q_full;
    assign in_ready = (step_reg == ST_EMPTY) || apply_go;
    assign take     = in_valid && in_ready;
    assign q_push   = apply_go;
    assign q_job    = job;

    always_comb
    begin
        case (step_reg)
            ST_EMPTY: step_next = take ? ST_EVAL : ST_EMPTY;
            ST_EVAL:  step_next = ST_APPLY;
            ST_APPLY: step_next = take ? ST_EVAL : (apply_go ? ST_EMPTY : ST_APPLY);
            default:  step_next = ST_EMPTY;
        endcase
    end

    // tick advances time when taken, the envelope step sees the new time
    assign now_next = (take && (in_data[1:0] == ACT_TICK)) ? now_reg + TIME_BITS'(1) : now_reg;

    // eval step: wrapping elapsed times and their compares
    assign dwell_sel  = fm_reg ? dwell_fm_reg : dwell_reg;
    assign ramp_total = {1'b0, precharge_reg} + {1'b0, bloom_reg};
    assign el_dwell   = now_reg - move_reg;
    assign el_ramp    = now_reg - ramp_reg;
    assign el_curve   = now_reg - ramp_reg - TIME_BITS'(precharge_reg);

    // apply step: curve value, floored and scaled by goal/63
    assign lut       = RAMP_ROM[8'(ev_idx_reg)];
    assign lut_floor = (lut < min_vol_reg) ? min_vol_reg : lut;
    assign goal      = muted_reg ? 6'd0 : target_reg;
    assign prod      = 12'(lut_floor) * 12'(goal);
    // x/63 = x/64 plus one when the remainder plus x/64 reaches 63
    assign quot      = prod[11:6];
    assign rem_sum   = {1'b0, prod[5:0]} + {1'b0, quot};
    assign bloom_vol = quot + 6'(rem_sum >= 7'd63);

    always_comb
    begin
        phase_next   = phase_reg;
        move_next    = move_reg;
        ramp_next    = ramp_reg;
        target_next  = target_reg;
        held_next    = held_reg;
        unmuted_next = unmuted_reg;
        active_next  = active_reg;
        muted_next   = muted_reg;
        fm_next      = fm_reg;
        job.last_k   = 2'd0;
        job.kind     = {MAX_RESULTS{CMD_NONE}};
        job.value    = '0;

        case (it_action_reg)
            ACT_TICK:
            begin
                if (active_reg)
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            held_next = target_reg;
                        end
                        PH_DROP:
                        begin
                            phase_next = PH_DWELL;
                        end
                        PH_DWELL:
                        begin
                            if (ev_dwell_done_reg)
                            begin
                                phase_next   = PH_BLOOM;
                                ramp_next    = now_reg;
                                unmuted_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (ev_ramp_end_reg)
                            begin
                                phase_next    = PH_IDLE;
                                held_next     = goal;
                                job.kind[0]   = CMD_VOL;
                                job.value[0]  = goal;
                            end
                            else if (ev_ramp_pre_reg)
                            begin
                                held_next     = 6'd1;
                                job.kind[0]   = CMD_VOL;
                                job.value[0]  = 6'd1;
                            end
                            else
                            begin
                                held_next = bloom_vol;
                                if (!unmuted_reg)
                                begin
                                    unmuted_next  = 1'b1;
                                    job.kind[0]   = CMD_MUTE;
                                    job.value[0]  = 6'd0;
                                    job.kind[1]   = CMD_VOL;
                                    job.value[1]  = bloom_vol;
                                    job.last_k    = 2'd1;
                                end
                                else
                                begin
                                    job.kind[0]   = CMD_VOL;
                                    job.value[0]  = bloom_vol;
                                end
                            end
                        end
                    endcase
                end
            end
            ACT_MOVE:
            begin
                move_next  = now_reg;
                phase_next = PH_DROP;
                if (soft_drop_reg)
                begin
                    job.kind[0]  = CMD_VOL;
                    job.value[0] = {1'b0, held_reg[5:1]};
                    job.kind[1]  = CMD_VOL;
                    job.value[1] = 6'd0;
                    job.kind[2]  = CMD_MUTE;
                    job.value[2] = 6'd1;
                    job.last_k   = 2'd2;
                end
                else
                begin
                    job.kind[0]  = CMD_MUTE;
                    job.value[0] = 6'd1;
                end
            end
            ACT_STATUS:
            begin
                active_next = it_active_reg;
                muted_next  = it_muted_reg;
                fm_next     = it_fm_reg;
                // leaving the allowed mode mid-envelope
                if (!it_active_reg && (phase_reg != PH_IDLE))
                begin
                    phase_next   = PH_IDLE;
                    held_next    = target_reg;
                    job.kind[0]  = CMD_MUTE;
                    job.value[0] = 6'd0;
                    job.kind[1]  = CMD_VOL;
                    job.value[1] = target_reg;
                    job.last_k   = 2'd1;
                end
            end
            default:
            begin
                target_next = (it_volume_reg > {2'b00, max_vol_reg}) ?
                              max_vol_reg : it_volume_reg[5:0];
            end
        endcase

        job.present = held_next;
        job.busy    = (phase_next != PH_IDLE);
        job.owns    = (phase_next == PH_DWELL) || (phase_next == PH_BLOOM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg     <= RST_DWELL;
            dwell_fm_reg  <= RST_DWELL_FM;
            precharge_reg <= RST_PRECHARGE;
            bloom_reg     <= RST_BLOOM;
            min_vol_reg   <= RST_MIN_VOLUME;
            max_vol_reg   <= RST_MAX_VOLUME;
            soft_drop_reg <= RST_SOFT_DROP;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_DWELL:      dwell_reg     <= cfg_wdata;
                CFG_DWELL_FM:   dwell_fm_reg  <= cfg_wdata;
                CFG_PRECHARGE:  precharge_reg <= cfg_wdata[9:0];
                CFG_BLOOM:      bloom_reg     <= cfg_wdata[9:0];
                CFG_MIN_VOLUME: min_vol_reg   <= cfg_wdata[5:0];
                CFG_MAX_VOLUME: max_vol_reg   <= cfg_wdata[5:0];
                CFG_SOFT_DROP:  soft_drop_reg <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_EMPTY;
            phase_reg   <= PH_IDLE;
            now_reg     <= '0;
            move_reg    <= '0;
            ramp_reg    <= '0;
            target_reg  <= RST_LEVEL;
            held_reg    <= RST_LEVEL;
            unmuted_reg <= 1'b0;
            active_reg  <= 1'b0;
            muted_reg   <= 1'b0;
            fm_reg      <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            now_reg  <= now_next;
            if (apply_go)
            begin
                phase_reg   <= phase_next;
                move_reg    <= move_next;
                ramp_reg    <= ramp_next;
                target_reg  <= target_next;
                held_reg    <= held_next;
                unmuted_reg <= unmuted_next;
                active_reg  <= active_next;
                muted_reg   <= muted_next;
                fm_reg      <= fm_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            it_action_reg <= in_data[1:0];
            it_active_reg <= in_data[2];
            it_muted_reg  <= in_data[3];
            it_fm_reg     <= in_data[4];
            it_volume_reg <= in_data[12:5];
        end
        if (step_reg == ST_EVAL)
        begin
            ev_dwell_done_reg <= (el_dwell >= TIME_BITS'(dwell_sel));
            ev_ramp_end_reg   <= (el_ramp >= TIME_BITS'(ramp_total));
            ev_ramp_pre_reg   <= (el_ramp < TIME_BITS'(precharge_reg));
            ev_idx_reg        <= (el_curve < TIME_BITS'(LAST_IDX)) ?
                                 el_curve[IDX_W-1:0] : IDX_W'(LAST_IDX);
        end
    end

endmodule

// ===== sv/tmve_back.sv =====
module tmve_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tmve_pkg::job_t head_job,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [15:0]    out_data,
    output logic           out_last
);
    import tmve_pkg::*;

    logic [1:0] k_reg;
    logic [1:0] k_next;
    logic       fire;

    assign out_valid = !empty;
    assign fire      = out_valid && out_ready;
    assign out_last  = (k_reg == head_job.last_k);
    assign pop       = fire && out_last;
    assign out_data  = {head_job.owns, head_job.busy, head_job.present,
                        head_job.value[k_reg], head_job.kind[k_reg]};

    always_comb
    begin
        k_next = k_reg;
        if (fire)
        begin
            k_next = out_last ? 2'd0 : k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 2'd0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

endmodule

// ===== sv/tune_mute_volume_envelope.sv =====
// channel   direction  payload                                              handshake
// s_axis    in         tdata: action, path_active, user_muted, is_fm,       tvalid/tready
//                      new_volume
// m_axis    out        tdata: command, command_value, present_volume,       tvalid/tready
//                      envelope_busy, owns_volume; tlast: last
// cfg       in         cfg_addr register index, cfg_wdata value             cfg_wr_en
//
// the front handles each item in an eval step (timing compares), then an apply step; the next item
// is taken in the apply step, so the front takes a new item while it hands the last one to the queue
// the back sends one result per cycle while m_axis_tready is high, one to three per item
// reset is asynchronous; envelope state, configuration and queue pointers reach their reset values at once
// a stalled m_axis fills the job queue, then the front holds its apply step and drops tready
module tune_mute_volume_envelope #(
    parameter int RAMP_TABLE_DEPTH = tmve_pkg::DEF_RAMP_TABLE_DEPTH,
    parameter int TIME_BITS        = tmve_pkg::DEF_TIME_BITS,
    parameter int QUEUE_DEPTH      = tmve_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [tmve_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tmve_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] action, [2] path_active, [3] user_muted, [4] is_fm, [12:5] new_volume
    input  logic [15:0]                     s_axis_tdata,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] command, [7:2] command_value, [13:8] present_volume,
    // [14] envelope_busy, [15] owns_volume
    output logic [15:0]                     m_axis_tdata,
    output logic                            m_axis_tlast
);
    import tmve_pkg::*;

    // front to queue
    logic q_full;
    logic q_push;
    job_t q_job;

    // queue to back
    job_t head_job;
    logic q_empty;
    logic q_pop;

    // front: holds the envelope state, classifies each item into a job
    tmve_front #(
        .RAMP_TABLE_DEPTH (RAMP_TABLE_DEPTH),
        .TIME_BITS        (TIME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // short job queue lets the front run ahead of a stalled output
    tmve_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // back: plays out the commands of each job, one result item per cycle while m_axis_tready is high
    tmve_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== test/tune_mute_volume_envelope_tb.sv =====
module tune_mute_volume_envelope_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmve_pkg::*;

    // envelope phases as the block steps through them
    typedef enum logic [1:0] {
        ENV_IDLE  = 2'd0,
        ENV_DROP  = 2'd1,
        ENV_DWELL = 2'd2,
        ENV_BLOOM = 2'd3
    } env_phase_t;

    // one input item
    typedef struct packed {
        logic [1:0] action;
        logic       path_active;
        logic       user_muted;
        logic       is_fm;
        logic [7:0] new_volume;
    } tune_item_t;

    // one result item
    typedef struct packed {
        logic [1:0]       command;
        logic [VOL_W-1:0] command_value;
        logic [VOL_W-1:0] present_volume;
        logic             envelope_busy;
        logic             owns_volume;
        logic             last;
    } env_cmd_t;

    // register index outside the list, written to check it is ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;
    localparam int FULL_SCALE  = 63;
    localparam int RAMP_LAST   = (DEF_RAMP_TABLE_DEPTH < RAMP_ROM_ENTRIES ?
                                  DEF_RAMP_TABLE_DEPTH : RAMP_ROM_ENTRIES) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    // stimulus side bookkeeping
    tune_item_t tuning_items[$];
    tune_item_t offered_item;
    env_cmd_t   expected_cmds[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    logic       hold_req = 1'b0;
    logic       hold_ack = 1'b0;
    int         hold_left = 0;

    // register copies for prediction
    logic [15:0] dwell_am_ms;
    logic [15:0] dwell_fm_ms;
    logic [9:0]  precharge_ms;
    logic [9:0]  ramp_ms;
    logic [5:0]  floor_level;
    logic [5:0]  ceiling_level;
    logic        soft_drop;

    // envelope state for prediction
    env_phase_t  env_phase;
    logic [31:0] now_ms;
    logic [31:0] moved_at;
    logic [31:0] ramp_from;
    logic [5:0]  target_level;
    logic [5:0]  held_level;
    logic        unmute_sent;
    logic        path_on;
    logic        user_mute;
    logic        fm_mode;

    // commands of the item being predicted
    logic [1:0]  cmd_kind [0:2];
    logic [5:0]  cmd_val  [0:2];
    int          cmd_n;

    tune_mute_volume_envelope DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // register and state values right after reset
    initial
    begin
        dwell_am_ms   = RST_DWELL;
        dwell_fm_ms   = RST_DWELL_FM;
        precharge_ms  = RST_PRECHARGE;
        ramp_ms       = RST_BLOOM;
        floor_level   = RST_MIN_VOLUME;
        ceiling_level = RST_MAX_VOLUME;
        soft_drop     = RST_SOFT_DROP;
        env_phase     = ENV_IDLE;
        now_ms        = '0;
        moved_at      = '0;
        ramp_from     = '0;
        target_level  = RST_LEVEL;
        held_level    = RST_LEVEL;
        unmute_sent   = 1'b0;
        path_on       = 1'b0;
        user_mute     = 1'b0;
        fm_mode       = 1'b0;
    end

    task automatic note_cmd(input logic [1:0] kind, input logic [5:0] val);
        if (cmd_n < MAX_RESULTS)
        begin
            cmd_kind[cmd_n] = kind;
            cmd_val[cmd_n]  = val;
            cmd_n++;
        end
    endtask

    // one millisecond step of the envelope, run after the clock advanced
    task automatic step_envelope();
        logic [31:0] elapsed;
        logic [31:0] ramp_pos;
        logic [5:0]  goal;
        logic [5:0]  lut;
        logic [11:0] scaled;
        int          idx;
        if (!path_on)
            return;
        case (env_phase)
            ENV_IDLE:
                held_level = target_level;
            ENV_DROP:
                env_phase = ENV_DWELL;
            ENV_DWELL:
            begin
                elapsed = now_ms - moved_at;
                if (elapsed >= 32'(fm_mode ? dwell_fm_ms : dwell_am_ms))
                begin
                    env_phase   = ENV_BLOOM;
                    ramp_from   = now_ms;
                    unmute_sent = 1'b0;
                end
            end
            default:
            begin
                elapsed = now_ms - ramp_from;
                goal = user_mute ? 6'd0 : target_level;
                if (elapsed >= 32'(precharge_ms) + 32'(ramp_ms))
                begin
                    // ramp done, settle on the goal
                    env_phase  = ENV_IDLE;
                    held_level = goal;
                    note_cmd(CMD_VOL, goal);
                end
                else if (elapsed < 32'(precharge_ms))
                begin
                    held_level = 6'd1;
                    note_cmd(CMD_VOL, 6'd1);
                end
                else
                begin
                    if (!unmute_sent)
                    begin
                        note_cmd(CMD_MUTE, 6'd0);
                        unmute_sent = 1'b1;
                    end
                    // past the table end the last entry holds
                    ramp_pos = elapsed - 32'(precharge_ms);
                    idx = (ramp_pos < 32'(RAMP_LAST)) ? int'(ramp_pos) : RAMP_LAST;
                    lut = RAMP_ROM[idx];
                    if (lut < floor_level)
                        lut = floor_level;
                    scaled = (goal == 6'd0) ? 12'd0 :
                             12'((12'(lut) * 12'(goal)) / FULL_SCALE);
                    held_level = scaled[5:0];
                    note_cmd(CMD_VOL, held_level);
                end
            end
        endcase
    endtask

    // work out the results of one accepted item and queue them
    task automatic advance_envelope(input tune_item_t it);
        env_cmd_t r;
        cmd_n = 0;
        case (it.action)
            ACT_TICK:
            begin
                now_ms = now_ms + 32'd1;
                step_envelope();
            end
            ACT_MOVE:
            begin
                // a move restarts the drop from any phase, active or not
                moved_at  = now_ms;
                env_phase = ENV_DROP;
                if (soft_drop)
                begin
                    note_cmd(CMD_VOL, held_level >> 1);
                    note_cmd(CMD_VOL, 6'd0);
                end
                note_cmd(CMD_MUTE, 6'd1);
            end
            ACT_STATUS:
            begin
                path_on   = it.path_active;
                user_mute = it.user_muted;
                fm_mode   = it.is_fm;
                if (!path_on && env_phase != ENV_IDLE)
                begin
                    env_phase = ENV_IDLE;
                    note_cmd(CMD_MUTE, 6'd0);
                    note_cmd(CMD_VOL, target_level);
                    held_level = target_level;
                end
            end
            default:
                target_level = (it.new_volume > 8'(ceiling_level)) ?
                               ceiling_level : it.new_volume[5:0];
        endcase
        // an item with no command still reports the status
        if (cmd_n == 0)
            note_cmd(CMD_NONE, 6'd0);
        for (int k = 0; k < cmd_n; k++)
        begin
            r.command        = cmd_kind[k];
            r.command_value  = cmd_val[k];
            r.present_volume = held_level;
            r.envelope_busy  = (env_phase != ENV_IDLE);
            r.owns_volume    = (env_phase == ENV_DWELL || env_phase == ENV_BLOOM);
            r.last           = (k == cmd_n - 1);
            expected_cmds.push_back(r);
        end
    endtask

    // driver: offers pending items, predicts each one on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_envelope(offered_item);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tuning_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered_item = tuning_items.pop_front();
                    s_axis_tdata  <= {3'b000, offered_item.new_volume, offered_item.is_fm,
                                      offered_item.user_muted, offered_item.path_active,
                                      offered_item.action};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result item and drives the receiver stalls
    always @(posedge clk)
    begin
        env_cmd_t got;
        env_cmd_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.command        = m_axis_tdata[1:0];
                got.command_value  = m_axis_tdata[7:2];
                got.present_volume = m_axis_tdata[13:8];
                got.envelope_busy  = m_axis_tdata[14];
                got.owns_volume    = m_axis_tdata[15];
                got.last           = m_axis_tlast;
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result cmd=%0d val=%0d vol=%0d busy=%0b own=%0b last=%0b",
                             $time, got.command, got.command_value, got.present_volume,
                             got.envelope_busy, got.owns_volume, got.last);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got.command != want.command || got.command_value != want.command_value ||
                        got.present_volume != want.present_volume ||
                        got.envelope_busy != want.envelope_busy ||
                        got.owns_volume != want.owns_volume || got.last != want.last)
                    begin
                        mismatches++;
                        $display("%0t: expected cmd=%0d val=%0d vol=%0d busy=%0b own=%0b last=%0b",
                                 $time, want.command, want.command_value, want.present_volume,
                                 want.envelope_busy, want.owns_volume, want.last);
                        $display("%0t: actual   cmd=%0d val=%0d vol=%0d busy=%0b own=%0b last=%0b",
                                 $time, got.command, got.command_value, got.present_volume,
                                 got.envelope_busy, got.owns_volume, got.last);
                    end
                end
            end
            // a long hold-off lets the block back up into its input
            if (hold_req != hold_ack)
            begin
                hold_ack      <= hold_req;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tune_mute_volume_envelope regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_DWELL:      dwell_am_ms   = value;
            CFG_DWELL_FM:   dwell_fm_ms   = value;
            CFG_PRECHARGE:  precharge_ms  = value[9:0];
            CFG_BLOOM:      ramp_ms       = value[9:0];
            CFG_MIN_VOLUME: floor_level   = value[5:0];
            CFG_MAX_VOLUME: ceiling_level = value[5:0];
            CFG_SOFT_DROP:  soft_drop     = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_regs(input logic [15:0] dwell, input logic [15:0] dwell_fm,
                             input logic [9:0] pre, input logic [9:0] ramp,
                             input logic [5:0] lo, input logic [5:0] hi, input logic drop);
        write_reg(CFG_DWELL, dwell);
        write_reg(CFG_DWELL_FM, dwell_fm);
        write_reg(CFG_PRECHARGE, 16'(pre));
        write_reg(CFG_BLOOM, 16'(ramp));
        write_reg(CFG_MIN_VOLUME, 16'(lo));
        write_reg(CFG_MAX_VOLUME, 16'(hi));
        write_reg(CFG_SOFT_DROP, 16'(drop));
    endtask

    function automatic tune_item_t mk_item(input logic [1:0] action, input logic active,
                                           input logic muted, input logic fm,
                                           input logic [7:0] vol);
        tune_item_t it;
        it.action      = action;
        it.path_active = active;
        it.user_muted  = muted;
        it.is_fm       = fm;
        it.new_volume  = vol;
        return it;
    endfunction

    // mostly ticks so that dwell and bloom play out, with moves, targets
    // and status changes mixed in; a status update usually keeps the path on
    function automatic tune_item_t random_item();
        tune_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it.path_active = ($urandom_range(0, 9) < 8);
        it.user_muted  = 1'($urandom_range(0, 1));
        it.is_fm       = 1'($urandom_range(0, 1));
        it.new_volume  = 8'($urandom_range(0, 255));
        if (pick < 60)
            it.action = ACT_TICK;
        else if (pick < 72)
            it.action = ACT_MOVE;
        else if (pick < 82)
            it.action = ACT_STATUS;
        else
            it.action = ACT_TARGET;
        return it;
    endfunction

    task automatic queue_random(input int count);
        tuning_items.push_back(mk_item(ACT_STATUS, 1'b1, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 255))));
        for (int i = 0; i < count; i++)
            tuning_items.push_back(random_item());
    endtask

    task automatic queue_ticks(input int count);
        for (int i = 0; i < count; i++)
            tuning_items.push_back(mk_item(ACT_TICK, 1'b0, 1'b0, 1'b0, 8'd0));
    endtask

    // wait for every item to go in and every result to come out
    task automatic drain();
        while (tuning_items.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: short timings so one move runs all the way through bloom
        set_idling(0, 0);
        load_regs(16'd2, 16'd4, 10'd2, 10'd6, 6'd5, 6'd40, 1'b1);
        write_reg(CFG_UNUSED, 16'hFFFF);
        tuning_items.push_back(mk_item(ACT_TICK, 1'b1, 1'b1, 1'b1, 8'hFF));     // path off
        tuning_items.push_back(mk_item(ACT_STATUS, 1'b1, 1'b0, 1'b0, 8'h00));   // idle status
        tuning_items.push_back(mk_item(ACT_TARGET, 1'b0, 1'b0, 1'b0, 8'hFF));   // clamped
        tuning_items.push_back(mk_item(ACT_TICK, 1'b0, 1'b0, 1'b0, 8'h00));
        tuning_items.push_back(mk_item(ACT_MOVE, 1'b0, 1'b0, 1'b0, 8'h00));
        queue_ticks(11);                                                       // drop to idle
        tuning_items.push_back(mk_item(ACT_STATUS, 1'b1, 1'b1, 1'b1, 8'h00));
        tuning_items.push_back(mk_item(ACT_MOVE, 1'b1, 1'b1, 1'b1, 8'hFF));
        queue_ticks(3);
        tuning_items.push_back(mk_item(ACT_STATUS, 1'b0, 1'b0, 1'b0, 8'h00));   // force idle
        tuning_items.push_back(mk_item(ACT_TARGET, 1'b1, 1'b1, 1'b1, 8'h00));
        drain();

        // no drop fade, floor at full scale, zero dwell
        load_regs(16'd0, 16'd1, 10'd0, 10'd3, 6'd63, 6'd63, 1'b0);
        queue_random(24);
        drain();

        // sender gaps
        set_idling(72, 0);
        load_regs(16'd3, 16'd5, 10'd1, 10'd10, 6'd2, 6'd50, 1'b1);
        queue_random(24);
        drain();

        // receiver stalls, longest timings and a zero ceiling
        set_idling(0, 72);
        load_regs(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 6'd0, 6'd0, 1'b1);
        queue_random(10);
        drain();

        // both sides idle, with a long hold-off at the start
        set_idling(32, 32);
        load_regs(16'd2, 16'd3, 10'd3, 10'd0, 6'd10, 6'd63, 1'b1);
        hold_req <= ~hold_req;
        queue_random(24);
        drain();

        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("tune_mute_volume_envelope regression: pass");
        else
            $display("tune_mute_volume_envelope regression: fail");
        $finish;
    end

endmodule
